FILE: design/ffsa_pkg.sv
// ffsa_pkg: shared types, constants and codes for the first-fit segment allocator
// no dependencies

package ffsa_pkg;

    localparam int MaxSegments = 32;
    localparam int AddrBits    = 16;
    localparam int IdxBits     = $clog2(MaxSegments);
    localparam int CntBits     = $clog2(MaxSegments + 1);

    localparam logic [15:0] MemoryReset = 16'd128;

    // result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_GROWN   = 3'd1;
    localparam logic [2:0] ST_SHRUNK  = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_NOMEM   = 3'd5;

    typedef logic [AddrBits-1:0] addr_t;
    typedef logic [IdxBits-1:0]  idx_t;
    typedef logic [CntBits-1:0]  cnt_t;

    // one table entry
    typedef struct packed {
        logic        hole;
        logic [15:0] pid;
        addr_t       seg_begin;
        addr_t       seg_end;
    } seg_t;

    // port of the segment memory
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        seg_t  wr_data;
    } mem_req_t;

    function automatic addr_t seg_len(seg_t s);
        seg_len = (s.seg_end >= s.seg_begin) ? addr_t'(s.seg_end - s.seg_begin) : '0;
    endfunction

endpackage

FILE: design/ffsa_seg_ram.sv
// ffsa_seg_ram: single-port-write, single-port-read segment table memory
// depends on ffsa_pkg

module ffsa_seg_ram (
    input  logic              aclk,
    input  ffsa_pkg::mem_req_t req,
    output ffsa_pkg::seg_t    rd_data
);

    ffsa_pkg::seg_t mem [ffsa_pkg::MaxSegments];

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port, a same-entry write is forwarded to the read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            if (req.wr_en && req.wr_addr == req.rd_addr) begin
                rd_data <= req.wr_data;
            end else begin
                rd_data <= mem[req.rd_addr];
            end
        end
    end

endmodule

FILE: design/ffsa_ctrl.sv
// ffsa_ctrl: sequencer that scans, shifts and compacts the segment table
// depends on ffsa_pkg

module ffsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        memory_size,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_process_id,
    input  logic signed [16:0] s_size_change,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [2:0]         m_status,
    output logic [15:0]        m_base_address,
    output logic [15:0]        m_free_total,
    output ffsa_pkg::mem_req_t mem_req,
    input  ffsa_pkg::seg_t     mem_rd
);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_FIND    = 5'd1;   // look for id
    localparam logic [4:0] S_DECIDE  = 5'd2;
    localparam logic [4:0] S_SPACE   = 5'd3;   // first fit scan
    localparam logic [4:0] S_LAST    = 5'd4;   // read last entry end
    localparam logic [4:0] S_TAILCHK = 5'd5;
    localparam logic [4:0] S_CMP     = 5'd6;   // compaction pass
    localparam logic [4:0] S_SHIFT   = 5'd7;   // move entries up by one
    localparam logic [4:0] S_PLACE   = 5'd8;
    localparam logic [4:0] S_FREE    = 5'd9;   // free total pass
    localparam logic [4:0] S_FREEEND = 5'd10;
    localparam logic [4:0] S_OUT     = 5'd11;
    localparam logic [4:0] S_SHRINK  = 5'd12;
    localparam logic [4:0] S_FAIL    = 5'd13;
    localparam logic [4:0] S_SPLIT   = 5'd14;

    localparam int CB = ffsa_pkg::CntBits;
    localparam int IB = ffsa_pkg::IdxBits;
    localparam ffsa_pkg::cnt_t CntMax = CB'(ffsa_pkg::MaxSegments);

    logic [4:0]           state_reg, state_next;
    ffsa_pkg::cnt_t       count_reg, count_next;
    ffsa_pkg::cnt_t       scan_reg, scan_next;     // entry whose data arrives now
    ffsa_pkg::cnt_t       wptr_reg, wptr_next;     // compaction write pointer
    logic                 pend_reg, pend_next;     // read data valid this cycle
    logic [15:0]          pid_reg, pid_next;
    logic signed [16:0]   delta_reg, delta_next;
    logic                 found_reg, found_next;
    ffsa_pkg::cnt_t       fidx_reg, fidx_next;
    ffsa_pkg::seg_t       fseg_reg, fseg_next;
    logic [17:0]          need_reg, need_next;
    logic                 grew_reg, grew_next;
    logic [15:0]          prev_reg, prev_next;
    logic                 retry_reg, retry_next;
    logic                 exact_reg, exact_next;
    ffsa_pkg::cnt_t       pos_reg, pos_next;
    ffsa_pkg::seg_t       pseg_reg, pseg_next;     // hole chosen, or carried entry
    ffsa_pkg::addr_t      last_reg, last_next;
    ffsa_pkg::addr_t      addr_reg, addr_next;
    logic [16:0]          sum_reg, sum_next;
    logic                 ok_reg, ok_next;
    logic [2:0]           status_reg, status_next;
    logic [15:0]          base_reg, base_next;
    logic                 mval_reg, mval_next;
    logic [15:0]          mfree_reg, mfree_next;
    logic [15:0]          mbase_reg, mbase_next;
    logic [2:0]           mstat_reg, mstat_next;
    logic                 mok_reg, mok_next;
    logic [1:0]           after_reg, after_next;   // what follows a shift pass

    localparam logic [1:0] AF_PLACE = 2'd0;
    localparam logic [1:0] AF_SPLIT = 2'd1;

    ffsa_pkg::addr_t usable;
    ffsa_pkg::addr_t rlen;
    logic            room;
    logic            busy;

    assign usable  = memory_size;
    assign rlen    = ffsa_pkg::seg_len(mem_rd);
    assign room    = count_reg < CntMax;
    assign busy    = state_reg != S_IDLE;
    assign s_ready = !busy && (!mval_reg || m_ready);

    assign m_valid        = mval_reg;
    assign m_ok           = mok_reg;
    assign m_status       = mstat_reg;
    assign m_base_address = mbase_reg;
    assign m_free_total   = mfree_reg;

    // sequencer
    always_comb begin
        ffsa_pkg::seg_t p;
        logic [17:0]    len18;
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        wptr_next   = wptr_reg;
        pend_next   = 1'b0;
        pid_next    = pid_reg;
        delta_next  = delta_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        fseg_next   = fseg_reg;
        need_next   = need_reg;
        grew_next   = grew_reg;
        prev_next   = prev_reg;
        retry_next  = retry_reg;
        exact_next  = exact_reg;
        pos_next    = pos_reg;
        pseg_next   = pseg_reg;
        last_next   = last_reg;
        addr_next   = addr_reg;
        sum_next    = sum_reg;
        ok_next     = ok_reg;
        status_next = status_reg;
        base_next   = base_reg;
        after_next  = after_reg;
        mval_next   = mval_reg && !m_ready;
        mfree_next  = mfree_reg;
        mbase_next  = mbase_reg;
        mstat_next  = mstat_reg;
        mok_next    = mok_reg;
        mem_req     = '0;
        p           = '0;
        len18       = '0;

        unique case (state_reg)
            // accept a transaction and start the id search
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    pid_next   = s_process_id;
                    delta_next = s_size_change;
                    found_next = 1'b0;
                    grew_next  = 1'b0;
                    retry_next = 1'b0;
                    ok_next    = 1'b0;
                    status_next = ffsa_pkg::ST_INVALID;
                    base_next  = '0;
                    scan_next  = '0;
                    if (count_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                        state_next      = S_FIND;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            // walk the table for the id
            S_FIND: begin
                if (pend_reg && !mem_rd.hole && mem_rd.pid == pid_reg) begin
                    found_next = 1'b1;
                    fidx_next  = scan_reg;
                    fseg_next  = mem_rd;
                    state_next = S_DECIDE;
                end else if (scan_reg + 1'b1 < count_reg) begin
                    scan_next       = scan_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IB'(scan_reg + 1'b1);
                    pend_next       = 1'b1;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            // branch on request kind
            S_DECIDE: begin
                if (found_reg) begin
                    len18 = 18'(ffsa_pkg::seg_len(fseg_reg));
                    if (delta_reg <= 0) begin
                        ok_next   = 1'b1;
                        base_next = fseg_reg.seg_begin;
                        if (delta_reg == 0 ||
                            $signed({1'b0, len18}) + 19'(delta_reg) <= 0) begin
                            p = fseg_reg;
                            p.hole = 1'b1;
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = IB'(fidx_reg);
                            mem_req.wr_data = p;
                            status_next     = ffsa_pkg::ST_REMOVED;
                            state_next      = S_FREE;
                        end else begin
                            status_next = ffsa_pkg::ST_SHRUNK;
                            state_next  = S_SHRINK;
                        end
                    end else begin
                        p = fseg_reg;
                        p.hole = 1'b1;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = IB'(fidx_reg);
                        mem_req.wr_data = p;
                        grew_next = 1'b1;
                        prev_next = ffsa_pkg::seg_len(fseg_reg);
                        need_next = len18 + 18'(delta_reg);
                        state_next = S_SPACE;
                        scan_next  = '0;
                        if (count_reg != '0) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            pend_next       = 1'b1;
                        end
                    end
                end else if (delta_reg <= 0) begin
                    state_next = S_FREE;
                end else begin
                    need_next  = 18'(delta_reg);
                    state_next = S_SPACE;
                    scan_next  = '0;
                    if (count_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                    end
                end
                if (state_next == S_FREE) begin
                    scan_next = '0;
                    sum_next  = '0;
                    if (count_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                    end
                end
            end
            // shrink: write new end, then make a hole behind it if possible
            S_SHRINK: begin
                p = fseg_reg;
                p.seg_end = ffsa_pkg::addr_t'(17'(fseg_reg.seg_begin)
                            + 17'(ffsa_pkg::seg_len(fseg_reg)) + 17'(delta_reg));
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IB'(fidx_reg);
                mem_req.wr_data = p;
                pseg_next       = p;
                if (fidx_reg + 1'b1 < count_reg && room) begin
                    after_next      = AF_SPLIT;
                    scan_next       = count_reg - 1'b1;
                    pos_next        = fidx_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IB'(count_reg - 1'b1);
                    pend_next       = 1'b1;
                    state_next      = S_SHIFT;
                end else begin
                    state_next = S_FREE;
                    scan_next  = '0;
                    sum_next   = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    pend_next       = 1'b1;
                end
            end
            S_SPLIT: begin
                p.hole      = 1'b1;
                p.pid       = pid_reg;
                p.seg_begin = pseg_reg.seg_end;
                p.seg_end   = ffsa_pkg::addr_t'(17'(fseg_reg.seg_begin)
                              + 17'(ffsa_pkg::seg_len(fseg_reg)));
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IB'(fidx_reg + 1'b1);
                mem_req.wr_data = p;
                count_next      = count_reg + 1'b1;
                state_next      = S_FREE;
                scan_next       = '0;
                sum_next        = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                pend_next       = 1'b1;
            end
            // first fit scan over holes
            S_SPACE: begin
                if (pend_reg && mem_rd.hole && 18'(rlen) >= need_reg &&
                    (18'(rlen) == need_reg || room)) begin
                    exact_next = 18'(rlen) == need_reg;
                    pos_next   = scan_reg;
                    pseg_next  = mem_rd;
                    if (18'(rlen) == need_reg || scan_reg + 1'b1 == count_reg) begin
                        state_next = S_PLACE;
                    end else begin
                        after_next      = AF_PLACE;
                        scan_next       = count_reg - 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = IB'(count_reg - 1'b1);
                        pend_next       = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end else if (pend_reg && scan_reg + 1'b1 < count_reg) begin
                    scan_next       = scan_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IB'(scan_reg + 1'b1);
                    pend_next       = 1'b1;
                end else begin
                    if (count_reg != '0) begin
                        last_next = pend_reg ? mem_rd.seg_end : last_reg;
                    end else begin
                        last_next = '0;
                    end
                    state_next = S_TAILCHK;
                end
            end
            // tail gap check, else compact or fail
            S_TAILCHK: begin
                if (room && last_reg <= usable &&
                    18'(usable - last_reg) >= need_reg) begin
                    exact_next = 1'b0;
                    pos_next   = count_reg;
                    pseg_next.seg_begin = last_reg;
                    state_next = S_PLACE;
                end else if (!retry_reg) begin
                    retry_next = 1'b1;
                    scan_next  = '0;
                    wptr_next  = '0;
                    addr_next  = '0;
                    if (count_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                        state_next      = S_CMP;
                    end else begin
                        state_next = S_SPACE;
                    end
                end else begin
                    state_next = S_FAIL;
                end
            end
            // compaction: pack processes from address zero
            S_CMP: begin
                if (pend_reg && !mem_rd.hole) begin
                    p.hole      = 1'b0;
                    p.pid       = mem_rd.pid;
                    p.seg_begin = addr_reg;
                    p.seg_end   = addr_reg + rlen;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = IB'(wptr_reg);
                    mem_req.wr_data = p;
                    addr_next = addr_reg + rlen;
                    wptr_next = wptr_reg + 1'b1;
                end
                if (scan_reg + 1'b1 < count_reg) begin
                    scan_next       = scan_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IB'(scan_reg + 1'b1);
                    pend_next       = 1'b1;
                end else begin
                    count_next = (pend_reg && !mem_rd.hole) ? wptr_reg + 1'b1 : wptr_reg;
                    last_next  = (pend_reg && !mem_rd.hole) ? addr_reg + rlen : addr_reg;
                    scan_next  = '0;
                    state_next = S_SPACE;
                    if (count_next != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                    end
                end
            end
            // move entries pos..count-1 up by one, top down
            S_SHIFT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IB'(scan_reg + 1'b1);
                mem_req.wr_data = mem_rd;
                if (scan_reg > pos_reg) begin
                    scan_next       = scan_reg - 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IB'(scan_reg - 1'b1);
                    pend_next       = 1'b1;
                end else if (after_reg == AF_SPLIT) begin
                    state_next = S_SPLIT;
                end else begin
                    state_next = S_PLACE;
                end
            end
            // write the process entry (and the remaining hole)
            S_PLACE: begin
                p.hole      = 1'b0;
                p.pid       = pid_reg;
                p.seg_begin = pseg_reg.seg_begin;
                p.seg_end   = pseg_reg.seg_begin + ffsa_pkg::addr_t'(need_reg);
                if (exact_reg || pos_reg == count_reg || !pend_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = IB'(pos_reg);
                    mem_req.wr_data = p;
                    if (!exact_reg) count_next = count_reg + 1'b1;
                    if (exact_reg || pos_reg == count_reg) begin
                        base_next   = p.seg_begin;
                        ok_next     = 1'b1;
                        status_next = grew_reg ? ffsa_pkg::ST_GROWN : ffsa_pkg::ST_ADDED;
                        state_next  = S_FREE;
                        scan_next   = '0;
                        sum_next    = '0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        pend_next       = 1'b1;
                    end else begin
                        // the trailing hole is written on the return to this state
                        pend_next = 1'b1;
                    end
                end else begin
                    p = pseg_reg;
                    p.seg_begin = pseg_reg.seg_begin + ffsa_pkg::addr_t'(need_reg);
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = IB'(pos_reg + 1'b1);
                    mem_req.wr_data = p;
                    base_next   = pseg_reg.seg_begin;
                    ok_next     = 1'b1;
                    status_next = grew_reg ? ffsa_pkg::ST_GROWN : ffsa_pkg::ST_ADDED;
                    state_next  = S_FREE;
                    scan_next   = '0;
                    sum_next    = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    pend_next       = 1'b1;
                end
            end
            // no space after compaction
            S_FAIL: begin
                status_next = ffsa_pkg::ST_NOMEM;
                ok_next     = 1'b0;
                base_next   = '0;
                if (grew_reg && room) begin
                    p.hole      = 1'b0;
                    p.pid       = pid_reg;
                    p.seg_begin = last_reg;
                    p.seg_end   = last_reg + prev_reg;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = IB'(count_reg);
                    mem_req.wr_data = p;
                    count_next = count_reg + 1'b1;
                    base_next  = last_reg;
                end
                state_next = S_FREE;
                scan_next  = '0;
                sum_next   = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                pend_next       = 1'b1;
            end
            // sum hole lengths and the tail gap
            S_FREE: begin
                if (count_reg == '0) begin
                    sum_next   = 17'(usable);
                    state_next = S_OUT;
                end else begin
                    if (mem_rd.hole) sum_next = sum_reg + 17'(rlen);
                    if (scan_reg + 1'b1 < count_reg) begin
                        scan_next       = scan_reg + 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = IB'(scan_reg + 1'b1);
                        pend_next       = 1'b1;
                    end else begin
                        last_next  = mem_rd.seg_end;
                        state_next = S_FREEEND;
                    end
                end
            end
            S_FREEEND: begin
                if (last_reg <= usable) begin
                    sum_next = sum_reg + 17'(usable - last_reg);
                end
                state_next = S_OUT;
            end
            // present the result
            S_OUT: begin
                if (!mval_reg || m_ready) begin
                    mval_next  = 1'b1;
                    mok_next   = ok_reg;
                    mstat_next = status_reg;
                    mbase_next = base_reg;
                    mfree_next = sum_reg[16] ? 16'hFFFF : sum_reg[15:0];
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mval_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mval_reg  <= mval_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        wptr_reg   <= wptr_next;
        pid_reg    <= pid_next;
        delta_reg  <= delta_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        fseg_reg   <= fseg_next;
        need_reg   <= need_next;
        grew_reg   <= grew_next;
        prev_reg   <= prev_next;
        retry_reg  <= retry_next;
        exact_reg  <= exact_next;
        pos_reg    <= pos_next;
        pseg_reg   <= pseg_next;
        last_reg   <= last_next;
        addr_reg   <= addr_next;
        sum_reg    <= sum_next;
        ok_reg     <= ok_next;
        status_reg <= status_next;
        base_reg   <= base_next;
        after_reg  <= after_next;
        mok_reg    <= mok_next;
        mstat_reg  <= mstat_next;
        mbase_reg  <= mbase_next;
        mfree_reg  <= mfree_next;
    end

endmodule

FILE: design/first_fit_segment_allocator_top.sv
// first_fit_segment_allocator_top: top level, config register, sequencer and segment memory
// depends on ffsa_pkg, ffsa_ctrl, ffsa_seg_ram
//
//  channel   direction  handshake        payload
//  s_        in         s_valid/s_ready  s_process_id, s_size_change
//  m_        out        m_valid/m_ready  m_ok, m_status, m_base_address, m_free_total
//  cfg       in         cfg_we           cfg_wdata (memory_size)
//
// one transaction at a time; it takes about 2 to 6 passes over the segment count,
// each pass one memory read per entry
// the single read port of the segment memory is why each pass reads one entry at a time
// synchronous active-low reset clears the count; the table needs no clearing pass
// a result waiting on m_ready holds off the next transaction: s_ready stays low until it is taken

module first_fit_segment_allocator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_process_id,
    input  logic signed [16:0] s_size_change,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [2:0]         m_status,
    output logic [15:0]        m_base_address,
    output logic [15:0]        m_free_total
);

    logic [15:0]        memory_size_reg;
    ffsa_pkg::mem_req_t mem_req;
    ffsa_pkg::seg_t     mem_rd;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_size_reg <= ffsa_pkg::MemoryReset;
        end else if (cfg_we) begin
            memory_size_reg <= cfg_wdata;
        end
    end

    ffsa_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .memory_size    (memory_size_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_process_id   (s_process_id),
        .s_size_change  (s_size_change),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_status       (m_status),
        .m_base_address (m_base_address),
        .m_free_total   (m_free_total),
        .mem_req        (mem_req),
        .mem_rd         (mem_rd)
    );

    ffsa_seg_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

endmodule

FILE: design/ffsa_checker.sv
// ffsa_checker: port-level assertions for the allocator top level
// depends on ffsa_pkg; bound to first_fit_segment_allocator_top

module ffsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [2:0]  m_status
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped while stalled");

    // ok agrees with the status code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ok == (m_status == ffsa_pkg::ST_ADDED ||
            m_status == ffsa_pkg::ST_GROWN || m_status == ffsa_pkg::ST_SHRUNK ||
            m_status == ffsa_pkg::ST_REMOVED)))
        else $error("ok and status disagree");

    // one transaction in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    // out of reset no result is shown
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_ok     (m_ok),
    .m_status (m_status)
);

FILE: bench/tb_top.sv
// tb_top: self-checking bench for first_fit_segment_allocator_top
// depends on ffsa_pkg and the allocator rtl; holds its own segment table predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int          TableDepth = ffsa_pkg::MaxSegments;
    localparam int unsigned AddrMask   = (1 << ffsa_pkg::AddrBits) - 1;
    localparam int          CycleLimit = 1000000;
    localparam int          SettleCycles = 600;

    typedef struct {
        bit          hole;
        int unsigned pid;
        int unsigned lo;
        int unsigned hi;
    } block_t;

    typedef struct {
        logic [15:0]        pid;
        logic signed [16:0] delta;
    } request_t;

    typedef struct {
        logic        ok;
        logic [2:0]  status;
        logic [15:0] base;
        logic [15:0] free_units;
    } reply_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_process_id = '0;
    logic signed [16:0] s_size_change = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok;
    logic [2:0]         m_status;
    logic [15:0]        m_base_address;
    logic [15:0]        m_free_total;

    // predictor state
    block_t      blocks [TableDepth];
    int unsigned block_count = 0;
    int unsigned capacity = ffsa_pkg::MemoryReset;

    request_t pending_requests [$];
    reply_t   expected_replies [$];
    int       fail_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    first_fit_segment_allocator_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_process_id   (s_process_id),
        .s_size_change  (s_size_change),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_status       (m_status),
        .m_base_address (m_base_address),
        .m_free_total   (m_free_total)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned span_of(int unsigned i);
        return (blocks[i].hi >= blocks[i].lo) ? blocks[i].hi - blocks[i].lo : 0;
    endfunction

    function automatic int unsigned usable_cap();
        return (capacity < AddrMask) ? capacity : AddrMask;
    endfunction

    function automatic int find_process(int unsigned id);
        for (int i = 0; i < block_count; i++) begin
            if (!blocks[i].hole && blocks[i].pid == id) return i;
        end
        return -1;
    endfunction

    // first fit over holes, then the tail gap; a split needs a free slot
    function automatic int first_fit(longint unsigned need, output bit exact);
        bit          room;
        int unsigned tail;
        room = block_count < TableDepth;
        exact = 1'b0;
        for (int i = 0; i < block_count; i++) begin
            if (blocks[i].hole && longint'(span_of(i)) >= need) begin
                if (longint'(span_of(i)) == need) begin
                    exact = 1'b1;
                    return i;
                end
                if (room) return i;
            end
        end
        tail = block_count ? blocks[block_count-1].hi : 0;
        if (room && tail <= usable_cap() && longint'(usable_cap() - tail) >= need)
            return block_count;
        return -1;
    endfunction

    function automatic int unsigned place_block(int unsigned idx, bit exact,
                                                int unsigned id, int unsigned need);
        int unsigned start;
        block_t      nb;
        if (idx < block_count) start = blocks[idx].lo;
        else start = block_count ? blocks[block_count-1].hi : 0;
        nb.hole = 1'b0;
        nb.pid = id;
        nb.lo = start;
        nb.hi = (start + need) & AddrMask;
        if (exact) begin
            blocks[idx] = nb;
        end else if (idx < block_count) begin
            for (int k = block_count; k > idx; k--) blocks[k] = blocks[k-1];
            blocks[idx] = nb;
            blocks[idx+1].lo = nb.hi;
            block_count++;
        end else begin
            blocks[block_count] = nb;
            block_count++;
        end
        return start;
    endfunction

    // drop holes and pack processes from address zero
    function automatic void pack_blocks();
        int unsigned j, addr, len;
        j = 0;
        addr = 0;
        for (int i = 0; i < block_count; i++) begin
            if (!blocks[i].hole) begin
                len = span_of(i);
                blocks[j].hole = 1'b0;
                blocks[j].pid = blocks[i].pid;
                blocks[j].lo = addr;
                blocks[j].hi = (addr + len) & AddrMask;
                addr = blocks[j].hi;
                j++;
            end
        end
        block_count = j;
    endfunction

    function automatic logic [15:0] free_space();
        longint unsigned sum;
        int unsigned     tail;
        sum = 0;
        if (block_count == 0) begin
            sum = usable_cap();
        end else begin
            for (int i = 0; i < block_count; i++)
                if (blocks[i].hole) sum += span_of(i);
            tail = blocks[block_count-1].hi;
            if (tail <= usable_cap()) sum += usable_cap() - tail;
        end
        return (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    // work out the reply to one request and update the table
    function automatic reply_t allocate(request_t rq);
        reply_t          r;
        int              idx, pos;
        int unsigned     id, len, prev, old_end, new_end;
        longint          d;
        longint unsigned need;
        bit              grew, exact;
        id = rq.pid;
        d = rq.delta;
        r.ok = 1'b0;
        r.status = ffsa_pkg::ST_INVALID;
        r.base = '0;
        grew = 1'b0;
        prev = 0;
        need = 0;
        idx = find_process(id);
        if (idx >= 0) begin
            len = span_of(idx);
            if (d <= 0) begin
                r.base = blocks[idx].lo[15:0];
                r.ok = 1'b1;
                if (d == 0 || longint'(len) + d <= 0) begin
                    blocks[idx].hole = 1'b1;
                    r.status = ffsa_pkg::ST_REMOVED;
                end else begin
                    old_end = blocks[idx].lo + len;
                    new_end = int'(longint'(old_end) + d);
                    blocks[idx].hi = new_end;
                    if (idx + 1 < block_count && block_count < TableDepth) begin
                        for (int k = block_count; k > idx + 1; k--) blocks[k] = blocks[k-1];
                        blocks[idx+1].hole = 1'b1;
                        blocks[idx+1].pid = id;
                        blocks[idx+1].lo = new_end;
                        blocks[idx+1].hi = old_end;
                        block_count++;
                    end
                    r.status = ffsa_pkg::ST_SHRUNK;
                end
                r.free_units = free_space();
                return r;
            end
            blocks[idx].hole = 1'b1;
            prev = len;
            grew = 1'b1;
            need = longint'(len) + d;
        end else if (d <= 0) begin
            r.free_units = free_space();
            return r;
        end else begin
            need = d;
        end
        pos = first_fit(need, exact);
        if (pos < 0) begin
            pack_blocks();
            pos = first_fit(need, exact);
        end
        if (pos < 0) begin
            r.status = ffsa_pkg::ST_NOMEM;
            if (grew && block_count < TableDepth)
                r.base = 16'(place_block(block_count, 1'b0, id, prev));
        end else begin
            r.base = 16'(place_block(pos, exact, id, 32'(need)));
            r.status = grew ? ffsa_pkg::ST_GROWN : ffsa_pkg::ST_ADDED;
            r.ok = 1'b1;
        end
        r.free_units = free_space();
        return r;
    endfunction

    // driver: present queued requests, predict at each accepted transaction
    always @(posedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                rq.pid = s_process_id;
                rq.delta = s_size_change;
                expected_replies.push_back(allocate(rq));
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_process_id <= rq.pid;
                s_size_change <= rq.delta;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure and field-by-field compare
    always @(posedge aclk) begin
        reply_t ex;
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result ok=%0d status=%0d base=%0d free=%0d",
                         $realtime, m_ok, m_status, m_base_address, m_free_total);
                fail_count++;
            end else begin
                ex = expected_replies.pop_front();
                if (m_ok !== ex.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $realtime, ex.ok, m_ok);
                    fail_count++;
                end
                if (m_status !== ex.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, ex.status, m_status);
                    fail_count++;
                end
                if (m_base_address !== ex.base) begin
                    $display("%0t: base_address expected %0d actual %0d",
                             $realtime, ex.base, m_base_address);
                    fail_count++;
                end
                if (m_free_total !== ex.free_units) begin
                    $display("%0t: free_total expected %0d actual %0d",
                             $realtime, ex.free_units, m_free_total);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_request(int unsigned id, int sz);
        request_t rq;
        rq.pid = id[15:0];
        rq.delta = sz[16:0];
        pending_requests.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_valid || expected_replies.size() > 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [15:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        capacity = v;
    endtask

    // random requests; small id pool so most hit known processes
    task automatic random_phase(int n, int id_pool);
        int unsigned id;
        int          sz, span, pick;
        span = (capacity / 8 > 0) ? capacity / 8 : 20;
        for (int k = 0; k < n; k++) begin
            id = ($urandom_range(99) < 88) ? $urandom_range(id_pool, 1) : $urandom_range(65535);
            pick = $urandom_range(99);
            if (pick < 50) sz = $urandom_range(span, 1);
            else if (pick < 78) sz = -int'($urandom_range(span, 1));
            else if (pick < 88) sz = 0;
            else sz = $urandom_range(65535) - ($urandom_range(1) ? 65535 : 0);
            add_request(id, sz);
        end
    endtask

    // stimulus sequence with settings between phases
    initial begin
        int unsigned caps [6];
        int          idle_sets [4][2];
        caps = '{16'd65535, 16'd0, 16'd40, 16'd3000, 16'd128, 16'd600};
        idle_sets = '{'{0, 0}, '{82, 0}, '{0, 82}, '{14, 14}};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        write_capacity(ffsa_pkg::MemoryReset);

        // directed corners at the reset capacity
        add_request(1, 10);
        add_request(2, 20);
        add_request(3, -5);
        add_request(1, 5);
        add_request(2, -5);
        add_request(9, 40);
        add_request(2, 0);
        add_request(4, 200);
        add_request(5, 65535);
        add_request(6, -65535);
        add_request(0, 3);
        add_request(65535, 1);
        add_request(1, -100);
        add_request(7, 15);
        add_request(9, 60);
        add_request(10, 10);
        add_request(11, 5);
        add_request(7, -3);
        add_request(11, 90);
        add_request(0, 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            send_idle_pct = idle_sets[p % 4][0];
            recv_stall_pct = idle_sets[p % 4][1];
            if (p > 0) write_capacity($urandom_range(1) ? caps[p % 6] : $urandom_range(65535));
            random_phase(60, (p % 2) ? 40 : 10);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
